### rtl/core/sfcb_pkg.sv
// Shared types and constants for the spanning forest cost/bottleneck block.
package sfcb_pkg;

    localparam int unsigned ANSWER_W = 28;
    localparam logic [ANSWER_W-1:0] ANSWER_MAX = 28'hFFFFFFF;
    localparam int unsigned NODE_W = 10;
    localparam int unsigned MAX_NODES = 1024;
    localparam int unsigned KEY_W = 16;
    localparam int unsigned EDGE_W = 2 * NODE_W + 2 * KEY_W;
    localparam int unsigned RANK_W = 4;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE_BY_YEAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b1;

    // Packed edge as held in the edge memory.
    typedef struct packed {
        logic [KEY_W-1:0]  cost;
        logic [KEY_W-1:0]  year;
        logic [NODE_W-1:0] to_node;
        logic [NODE_W-1:0] from_node;
    } t_edge;

endpackage

### rtl/core/sfcb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module sfcb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/spanning_forest_cost_or_bottleneck.sv
// Top level: edge loader, sequencer for sort and union-find scan, result register.
//
// Usage:
//  Slave stream s_axis_* carries one edge per item; s_axis_tdata packs
//  {cost, year, to_node, from_node} (from_node lowest), there is no tuser,
//  and s_axis_tlast marks the last edge of a graph. Edges load one per cycle
//  into the edge memory. On the last edge the block stops taking items,
//  sorts the stored edges (stable insertion sort held in the edge memory:
//  read edge i, read its neighbour, compare, shift each larger edge up,
//  write edge i; at most E*(E-1)/2 shifts) by year or by cost, then runs
//  a union-find over the parent and rank memories (each find step reads a
//  parent, path compression is a second walk that rewrites each parent to
//  the root, and a join reads both ranks and links one root under the other).
//  Before the scan the forest memories are cleared, one node per cycle, all
//  MAX_NODES nodes; the same clearing runs after reset, during which no
//  item is accepted. One 28-bit answer appears on m_axis_*; it holds while
//  m_axis_tready is low and loading of the next graph may already begin
//  while it waits. The user must write configuration (i_cfg_we/i_cfg_idx/
//  i_cfg_data) only while idle; the block itself does not enforce this.
//  Reset is synchronous, active low.
module spanning_forest_cost_or_bottleneck #(
    parameter int unsigned MAX_EDGES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata, // from_node[9:0], to_node, year, cost, pad
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata, // answer[27:0], zero pad
    input  logic        i_cfg_we,
    input  logic [sfcb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfcb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int unsigned MAX_NODES = sfcb_pkg::MAX_NODES;
    localparam int unsigned EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int unsigned EC_W = $clog2(MAX_EDGES + 1);
    localparam int unsigned NA_W = $clog2(MAX_NODES);
    localparam int unsigned NC_W = $clog2(MAX_NODES + 1);
    localparam int unsigned NW = sfcb_pkg::NODE_W;
    localparam int unsigned KW = sfcb_pkg::KEY_W;

    typedef enum logic [14:0] {
        S_CLR   = 15'h0001, S_LOAD  = 15'h0002, S_SRDA = 15'h0004,
        S_SRDB  = 15'h0008, S_SCMP  = 15'h0010, S_SWR  = 15'h0020,
        S_ERD   = 15'h0040, S_EGET  = 15'h0080, S_FRD  = 15'h0100,
        S_FGET  = 15'h0200, S_CRD   = 15'h0400, S_CGET = 15'h0800,
        S_JRD   = 15'h1000, S_JGET  = 15'h2000, S_DONE = 15'h4000
    } t_state;

    t_state r_state, n_state;

    // Configuration.
    logic                      r_mode;
    logic [sfcb_pkg::CFG_DATA_W-1:0] r_ncount;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_ncount <= 11'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfcb_pkg::CFG_MODE_BY_YEAR: r_mode <= i_cfg_data[0];
                sfcb_pkg::CFG_NODE_COUNT:   r_ncount <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Memories.
    logic               e_we;
    logic [EA_W-1:0]    e_waddr, e_raddr;
    sfcb_pkg::t_edge    e_wdata, e_rdata;
    logic               p_we, k_we;
    logic [NA_W-1:0]    p_waddr, p_raddr, k_waddr, k_raddr;
    logic [NW-1:0]      p_wdata, p_rdata;
    logic [sfcb_pkg::RANK_W-1:0] k_wdata, k_rdata;

    sfcb_ram #(.WIDTH(sfcb_pkg::EDGE_W), .DEPTH(MAX_EDGES)) u_edges (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata));
    sfcb_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_parent (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata));
    sfcb_ram #(.WIDTH(sfcb_pkg::RANK_W), .DEPTH(MAX_NODES)) u_rank (
        .i_clk(i_clk), .i_we(k_we), .i_waddr(k_waddr), .i_wdata(k_wdata),
        .i_raddr(k_raddr), .o_rdata(k_rdata));

    // Control registers.
    logic [EC_W-1:0] r_cnt, n_cnt;       // edges stored
    logic [EC_W-1:0] r_i, n_i;           // outer index
    logic [EC_W-1:0] r_j, n_j;           // insertion position
    logic [NC_W-1:0] r_clr, n_clr;
    logic            r_run, n_run;       // clearing belongs to a run
    sfcb_pkg::t_edge r_ins, n_ins;       // edge being inserted
    sfcb_pkg::t_edge r_cur, n_cur;
    logic [NW-1:0]   r_x, n_x, r_ra, n_ra, r_rt, n_rt;
    logic            r_side, n_side;     // 0: from endpoint, 1: to endpoint
    logic [sfcb_pkg::RANK_W-1:0] r_rka, n_rka;
    logic [sfcb_pkg::ANSWER_W-1:0] r_ans, n_ans;
    logic            r_ovalid, n_ovalid;
    logic [sfcb_pkg::ANSWER_W-1:0] r_odata, n_odata;

    sfcb_pkg::t_edge s_edge;
    assign s_edge = sfcb_pkg::t_edge'(s_axis_tdata[sfcb_pkg::EDGE_W-1:0]);

    logic [NC_W-1:0] eff_n;
    assign eff_n = ({1'b0, r_ncount} > 12'(MAX_NODES)) ? NC_W'(MAX_NODES)
                 : NC_W'(r_ncount);

    function automatic logic [KW-1:0] key_of(input sfcb_pkg::t_edge e, input logic m);
        key_of = m ? e.year : e.cost;
    endfunction

    logic in_acc;
    assign s_axis_tready = (r_state == S_LOAD);
    assign in_acc = s_axis_tvalid && s_axis_tready;

    logic [sfcb_pkg::ANSWER_W:0] sum;
    assign sum = {1'b0, r_ans} + {{(sfcb_pkg::ANSWER_W+1-KW){1'b0}}, r_cur.cost};

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_i = r_i; n_j = r_j; n_clr = r_clr;
        n_run = r_run; n_ins = r_ins; n_cur = r_cur; n_x = r_x; n_ra = r_ra;
        n_rt = r_rt; n_side = r_side; n_rka = r_rka; n_ans = r_ans;
        n_ovalid = r_ovalid; n_odata = r_odata;
        e_we = 1'b0; e_waddr = EA_W'(r_cnt); e_wdata = s_edge; e_raddr = '0;
        p_we = 1'b0; p_waddr = r_clr[NA_W-1:0]; p_wdata = NW'(r_clr);
        p_raddr = r_x[NA_W-1:0];
        k_we = 1'b0; k_waddr = r_clr[NA_W-1:0]; k_wdata = '0;
        k_raddr = r_x[NA_W-1:0];
        if (r_ovalid && m_axis_tready) n_ovalid = 1'b0;
        case (r_state)
            S_CLR: begin
                p_we = 1'b1; k_we = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == NC_W'(MAX_NODES - 1)) begin
                    n_clr = '0;
                    n_state = r_run ? S_ERD : S_LOAD;
                    n_i = '0;
                end
            end
            S_LOAD: begin
                if (in_acc) begin
                    if (r_cnt < EC_W'(MAX_EDGES)) begin
                        e_we = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_i = EC_W'(1);
                        n_state = S_SRDA;
                    end
                end
            end
            // insertion sort: take edge i, shift larger ones up
            S_SRDA: begin
                if (r_i >= r_cnt) begin
                    n_run = 1'b1; n_clr = '0; n_state = S_CLR;
                end else begin
                    e_raddr = EA_W'(r_i);
                    n_j = r_i;
                    n_state = S_SRDB;
                end
            end
            S_SRDB: begin
                n_ins = e_rdata;
                e_raddr = EA_W'(r_j - 1'b1);
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (key_of(r_ins, r_mode) < key_of(e_rdata, r_mode)) begin
                    e_we = 1'b1; e_waddr = EA_W'(r_j); e_wdata = e_rdata;
                    n_j = r_j - 1'b1;
                    if (r_j == EC_W'(1)) begin
                        n_j = '0; n_state = S_SWR;
                    end else begin
                        e_raddr = EA_W'(r_j - EC_W'(2));
                    end
                end else begin
                    n_state = S_SWR;
                end
            end
            S_SWR: begin
                e_we = 1'b1; e_waddr = EA_W'(r_j); e_wdata = r_ins;
                n_i = r_i + 1'b1;
                n_state = S_SRDA;
            end
            // scan
            S_ERD: begin
                if (r_i >= r_cnt) begin
                    n_state = S_DONE;
                end else begin
                    e_raddr = EA_W'(r_i);
                    n_state = S_EGET;
                end
            end
            S_EGET: begin
                n_cur = e_rdata;
                n_i = r_i + 1'b1;
                if ({1'b0, e_rdata.from_node} >= eff_n || {1'b0, e_rdata.to_node} >= eff_n)
                    n_state = S_ERD;
                else begin
                    n_x = e_rdata.from_node; n_side = 1'b0; n_state = S_FRD;
                end
            end
            S_FRD: begin
                p_raddr = r_x[NA_W-1:0];
                n_state = S_FGET;
            end
            S_FGET: begin
                if (p_rdata == r_x) begin
                    n_rt = r_x;
                    n_x = r_side ? r_cur.to_node : r_cur.from_node;
                    n_state = S_CRD;
                end else begin
                    n_x = p_rdata; n_state = S_FRD;
                end
            end
            S_CRD: begin
                p_raddr = r_x[NA_W-1:0];
                n_state = S_CGET;
            end
            S_CGET: begin
                if (r_x == r_rt) begin
                    if (!r_side) begin
                        n_ra = r_rt; n_side = 1'b1; n_x = r_cur.to_node;
                        n_state = S_FRD;
                    end else if (r_ra == r_rt) begin
                        n_state = S_ERD;
                    end else begin
                        n_x = r_ra; n_state = S_JRD;
                    end
                end else begin
                    p_we = 1'b1; p_waddr = r_x[NA_W-1:0]; p_wdata = r_rt;
                    n_x = p_rdata; n_state = S_CRD;
                end
            end
            S_JRD: begin
                k_raddr = r_x[NA_W-1:0];
                n_state = S_JGET;
            end
            S_JGET: begin
                if (r_x == r_ra) begin
                    n_rka = k_rdata; n_x = r_rt; n_state = S_JRD;
                end else begin
                    // k_rdata is rank of rb
                    if (r_rka < k_rdata) begin
                        p_we = 1'b1; p_waddr = r_ra[NA_W-1:0]; p_wdata = r_rt;
                    end else begin
                        p_we = 1'b1; p_waddr = r_rt[NA_W-1:0]; p_wdata = r_ra;
                        if (r_rka == k_rdata) begin
                            k_we = 1'b1; k_waddr = r_ra[NA_W-1:0];
                            k_wdata = r_rka + 1'b1;
                        end
                    end
                    if (r_mode) n_ans = 28'(r_cur.year);
                    else n_ans = sum[sfcb_pkg::ANSWER_W] ? sfcb_pkg::ANSWER_MAX
                                 : sum[sfcb_pkg::ANSWER_W-1:0];
                    n_state = S_ERD;
                end
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1; n_odata = r_ans;
                    n_ans = '0; n_cnt = '0; n_run = 1'b0; n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // JRD reads rank at r_x (ra then rb)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_cnt <= '0; r_clr <= '0; r_run <= 1'b0;
            r_ans <= '0; r_ovalid <= 1'b0; r_i <= '0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_clr <= n_clr; r_run <= n_run;
            r_ans <= n_ans; r_ovalid <= n_ovalid; r_i <= n_i;
        end
        r_j <= n_j; r_ins <= n_ins; r_cur <= n_cur; r_x <= n_x; r_ra <= n_ra;
        r_rt <= n_rt; r_side <= n_side; r_rka <= n_rka; r_odata <= n_odata;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_odata};

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !s_axis_tready) else $error("accept while busy");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= EC_W'(MAX_EDGES)) else $error("edge count overflow");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> (r_ovalid && $stable(r_odata)))
        else $error("result lost");
endmodule
